FILE: rtl/ifaf_pkg.sv
package ifaf_pkg;

    // Widths of the item fields.
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 3;
    localparam int W_BITS  = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = VALUE_W + MODE_W + W_BITS + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // Widest field that the formatter will produce.
    localparam int MAX_WIDTH = 31;

    // Enough digit slots for a 32-bit magnitude in octal (2^31 needs eleven).
    localparam int DIGIT_CAP = 11;
    localparam int DIG_IDX_W = $clog2(DIGIT_CAP);
    localparam int DIG_CNT_W = $clog2(DIGIT_CAP + 1);

    // Depth of the descriptor queue between the two halves.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT.
    localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int                 RECIP10_SHIFT = 35;

    // Conversion modes.
    localparam logic [MODE_W-1:0] MODE_DEC       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEC_BLANK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OCT       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEX_LO    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HEX_UP    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNS       = 3'd5;

    // Characters.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_UPPER = 8'h41;

    typedef enum logic [1:0] {
        RAD_DEC,
        RAD_OCT,
        RAD_HEX
    } radix_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SIGN_PRE,
        B_PAD_PRE,
        B_SIGN_POST,
        B_DIGITS,
        B_PAD_POST,
        B_STAR
    } phase_t;

    // One classified item, ready to be spelt out by the back end.
    typedef struct packed {
        logic [DIGIT_CAP-1:0][3:0] digits;
        logic [DIG_CNT_W-1:0]      ndig;
        logic                      neg;
        logic                      zero_fill;
        logic                      pad_right;
        logic                      upper;
        logic                      blank;
        logic                      overflow;
        logic [W_BITS-1:0]         width;
        logic [W_BITS-1:0]         pad;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: rtl/integer_ascii_field_formatter.sv
// The front end takes no new item until it has queued the last one, and is paced by its
// one-digit-per-cycle conversion loop; the back end gives one character per cycle from
// its sequencer while the receiver is ready, so the slower of the two sets the rate.
// Reset: aresetn is synchronous and active low; it empties the queue and idles both
// halves. No clearing pass is needed.
module integer_ascii_field_formatter
    import ifaf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, lowest bit up: value[31:0], mode[34:32], field_width[39:35],
    // zero_fill[40], pad_right[41], zeros[47:42].
    input  logic [S_TDATA_W-1:0] s_tdata,

    // Result items, one character each.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, lowest bit up: out_char[7:0].
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tlast marks the final character of an item's field.
    output logic                 m_tlast,
    // m_tuser, lowest bit up: overflowed[0].
    output logic [0:0]           m_tuser
);

    // The front end accepts an item, takes its magnitude apart into digits
    // (one per cycle, a reciprocal multiply for decimal and a shift for octal
    // and hex) and checks whether the field fits. The resulting descriptor is
    // queued, so the front end can work on the next item while the back end
    // is still spelling out the previous one.

    desc_t     push_data;
    desc_t     head;
    logic      push;
    logic      pop;
    q_status_t q_status;

    ifaf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    ifaf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // The back end walks the field in order: a leading minus sign for zero
    // fill, leading padding, a minus sign for space fill, the digits from the
    // most significant down, then trailing padding. An overflowed field is
    // field-width asterisks instead. Its output register lets it prepare the
    // next character while the current one still waits to be taken.
    ifaf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/ifaf_front.sv
module ifaf_front
    import ifaf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  q_status_t            q_status,
    output logic                 push,
    output desc_t                push_data
);

    front_state_t state_reg, state_next;

    logic [VALUE_W-1:0]   mag_reg;
    radix_t               rad_reg;
    logic [W_BITS-1:0]    w_reg;
    logic                 neg_reg;
    logic                 zf_reg;
    logic                 lj_reg;
    logic                 upper_reg;
    logic                 blank_reg;
    logic [DIG_CNT_W-1:0] n_reg;
    logic [3:0]           dig_reg [DIGIT_CAP];

    // Fields of the incoming item.
    logic [VALUE_W-1:0] in_value;
    logic [MODE_W-1:0]  in_mode;
    logic [W_BITS-1:0]  in_width;
    logic               in_zf;
    logic               in_lj;
    logic [MODE_W-1:0]  mode_n;
    logic               in_neg;
    logic [VALUE_W-1:0] in_mag;
    logic [W_BITS-1:0]  w_sat;
    radix_t             in_rad;

    // One digit step.
    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   q_dec;
    logic [VALUE_W-1:0]   rem_dec;
    logic [VALUE_W-1:0]   quot;
    logic [3:0]           digit;

    // Fit check.
    logic [W_BITS:0] avail;
    logic [W_BITS:0] n_ext;
    logic            ovf;

    logic accept;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_mode  = s_tdata[VALUE_W +: MODE_W];
    assign in_width = s_tdata[VALUE_W+MODE_W +: W_BITS];
    assign in_zf    = s_tdata[VALUE_W+MODE_W+W_BITS];
    assign in_lj    = s_tdata[VALUE_W+MODE_W+W_BITS+1];

    always_comb begin
        mode_n = (in_mode > MODE_UNS) ? MODE_DEC : in_mode;
        in_neg = (mode_n != MODE_UNS) && in_value[VALUE_W-1];
        in_mag = in_neg ? (~in_value + VALUE_W'(1)) : in_value;
        w_sat  = (int'(in_width) > MAX_WIDTH) ? W_BITS'(MAX_WIDTH) : in_width;
        case (mode_n)
            MODE_OCT:                 in_rad = RAD_OCT;
            MODE_HEX_LO, MODE_HEX_UP: in_rad = RAD_HEX;
            default:                  in_rad = RAD_DEC;
        endcase
    end

    always_comb begin
        prod    = (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP10);
        q_dec   = VALUE_W'(prod >> RECIP10_SHIFT);
        rem_dec = mag_reg - (q_dec << 3) - (q_dec << 1);
        case (rad_reg)
            RAD_OCT: begin
                quot  = mag_reg >> 3;
                digit = {1'b0, mag_reg[2:0]};
            end
            RAD_HEX: begin
                quot  = mag_reg >> 4;
                digit = mag_reg[3:0];
            end
            default: begin
                quot  = q_dec;
                digit = rem_dec[3:0];
            end
        endcase
    end

    always_comb begin
        avail = {1'b0, w_reg} - (W_BITS + 1)'(neg_reg);
        n_ext = (W_BITS + 1)'(n_reg);
        ovf   = (w_reg != '0) && (n_ext > avail);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                if ((quot == '0) || (n_reg == DIG_CNT_W'(DIGIT_CAP - 1))) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_status.full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = (state_reg == F_IDLE);
        push     = (state_reg == F_PUSH) && !q_status.full;
        for (int i = 0; i < DIGIT_CAP; i++) begin
            push_data.digits[i] = dig_reg[i];
        end
        push_data.ndig      = n_reg;
        push_data.neg       = neg_reg;
        push_data.zero_fill = zf_reg;
        push_data.pad_right = lj_reg;
        push_data.upper     = upper_reg;
        push_data.blank     = blank_reg;
        push_data.overflow  = ovf;
        push_data.width     = w_reg;
        push_data.pad       = (w_reg != '0 && !ovf) ? W_BITS'(avail - n_ext) : '0;
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_reg   <= in_mag;
            rad_reg   <= in_rad;
            w_reg     <= w_sat;
            neg_reg   <= in_neg;
            zf_reg    <= in_zf;
            lj_reg    <= in_lj;
            upper_reg <= (mode_n == MODE_HEX_UP);
            blank_reg <= (mode_n == MODE_DEC_BLANK) && (in_mag == '0);
            n_reg     <= '0;
        end else if (state_reg == F_CONV) begin
            dig_reg[n_reg[DIG_IDX_W-1:0]] <= digit;
            mag_reg <= quot;
            n_reg   <= n_reg + DIG_CNT_W'(1);
        end
    end

endmodule

FILE: rtl/ifaf_queue.sv
module ifaf_queue
    import ifaf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  desc_t     push_data,
    input  logic      pop,
    output desc_t     head,
    output q_status_t status
);

    desc_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

    function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/ifaf_back.sv
module ifaf_back
    import ifaf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  desc_t                head,
    input  q_status_t            q_status,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [0:0]           m_tuser
);

    phase_t            phase_reg, phase_next;
    logic [W_BITS-1:0] cnt_reg, cnt_next;
    desc_t             desc_reg, desc_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;
    logic                 m_ovf_reg;

    logic                 fire;
    logic                 phase_end;
    phase_t               follow;
    phase_t               first;
    logic [3:0]           cur_digit;
    logic [7:0]           cur_char;
    logic                 cur_last;
    logic [7:0]           pad_char;

    // Phase that follows p for descriptor d; B_IDLE ends the item.
    function automatic phase_t phase_after(phase_t p, desc_t d);
        logic   pre_sign;
        logic   pad_pre;
        logic   post_sign;
        logic   pad_post;
        phase_t r;
        pre_sign  = d.neg && d.zero_fill;
        post_sign = d.neg && !d.zero_fill;
        pad_pre   = !d.pad_right && (d.pad != '0);
        pad_post  = d.pad_right && (d.pad != '0);
        r         = B_IDLE;
        case (p)
            B_IDLE: begin
                if (d.overflow)      r = B_STAR;
                else if (pre_sign)   r = B_SIGN_PRE;
                else if (pad_pre)    r = B_PAD_PRE;
                else if (post_sign)  r = B_SIGN_POST;
                else                 r = B_DIGITS;
            end
            B_SIGN_PRE: begin
                r = pad_pre ? B_PAD_PRE : B_DIGITS;
            end
            B_PAD_PRE: begin
                r = post_sign ? B_SIGN_POST : B_DIGITS;
            end
            B_SIGN_POST: r = B_DIGITS;
            B_DIGITS: begin
                r = pad_post ? B_PAD_POST : B_IDLE;
            end
            default: r = B_IDLE;
        endcase
        return r;
    endfunction

    // Characters left after the first one of phase p.
    function automatic logic [W_BITS-1:0] phase_len(phase_t p, desc_t d);
        logic [W_BITS-1:0] r;
        case (p)
            B_PAD_PRE, B_PAD_POST: r = d.pad - W_BITS'(1);
            B_DIGITS:              r = W_BITS'(d.ndig) - W_BITS'(1);
            B_STAR:                r = d.width - W_BITS'(1);
            default:               r = '0;
        endcase
        return r;
    endfunction

    assign pop       = (phase_reg == B_IDLE) && !q_status.empty;
    assign fire      = (phase_reg != B_IDLE) && (!m_valid_reg || m_tready);
    assign phase_end = (cnt_reg == '0);
    assign follow    = phase_after(phase_reg, desc_reg);
    assign first     = phase_after(B_IDLE, head);

    // Next state.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        desc_next  = desc_reg;
        if (pop) begin
            desc_next  = head;
            phase_next = first;
            cnt_next   = phase_len(first, head);
        end else if (fire) begin
            if (phase_end) begin
                phase_next = follow;
                cnt_next   = phase_len(follow, desc_reg);
            end else begin
                cnt_next = cnt_reg - W_BITS'(1);
            end
        end
    end

    // Outputs: the character of the current phase position.
    always_comb begin
        cur_digit = desc_reg.digits[cnt_reg[DIG_IDX_W-1:0]];
        pad_char  = desc_reg.zero_fill ? CH_ZERO : CH_SPACE;
        cur_last  = phase_end && (follow == B_IDLE);
        case (phase_reg)
            B_SIGN_PRE, B_SIGN_POST: cur_char = CH_MINUS;
            B_PAD_PRE, B_PAD_POST:   cur_char = pad_char;
            B_STAR:                  cur_char = CH_STAR;
            B_DIGITS: begin
                if (desc_reg.blank) begin
                    cur_char = CH_SPACE;
                end else if (cur_digit < 4'd10) begin
                    cur_char = CH_ZERO + 8'(cur_digit);
                end else begin
                    cur_char = (desc_reg.upper ? CH_UPPER : CH_LOWER)
                             + 8'(cur_digit) - 8'd10;
                end
            end
            default: cur_char = CH_SPACE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= B_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        if (fire) begin
            m_data_reg <= cur_char;
            m_last_reg <= cur_last;
            m_ovf_reg  <= desc_reg.overflow;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

`ifndef NO_ASSERTIONS
    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cur_last) |=> (phase_reg == B_IDLE))
        else $error("sequencer kept running after the final character");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> ((phase_reg == B_IDLE) && !q_status.empty))
        else $error("descriptor taken while busy or queue empty");

    a_overflow_stars: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ovf_reg) |-> (m_data_reg == CH_STAR))
        else $error("overflowed item carries a character other than an asterisk");

    a_nonlast_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !cur_last) |=> (phase_reg != B_IDLE))
        else $error("item ended without its final character");
`endif

endmodule

FILE: test/integer_ascii_field_formatter_tb.sv
module integer_ascii_field_formatter_tb;
    import ifaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Modes 6 and 7 are not named by the package; the block treats them as signed decimal.
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // The slowest legal run is about 185 items of 31 characters each, with the receiver
    // stalling half of the time, so this limit is ample.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    // Characters may still be in flight after an item goes in.
    localparam int unsigned SETTLE_CYCLES = 32;
    // Only this many mismatch lines are printed; all of them are counted.
    localparam int unsigned MAX_REPORTS = 40;

    // One character of a formatted field as it should appear on the result channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       overflowed;
    } field_char_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;

    // Characters still owed by the block, oldest first.
    field_char_t expected_chars_q[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    // Chance, in percent, that the sender or the receiver idles in a given cycle.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    integer_ascii_field_formatter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The run is stopped outright if it has not finished after a generous number of cycles.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver stalls at random, at whatever rate the current phase has set.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Prints one line per mismatch (up to a cap) and counts every one of them.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s, got 'h%0h, want 'h%0h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Works out the characters of one formatted field and appends them to the queue of
    // characters still owed. Digits are collected least significant first.
    function automatic void format_field(input logic [VALUE_W-1:0] value,
                                         input logic [MODE_W-1:0] mode_in,
                                         input logic [W_BITS-1:0] width,
                                         input logic zero_fill,
                                         input logic pad_right);
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] mag;
        logic [7:0]         letter;
        logic [7:0]         fill_ch;
        logic               neg;
        int unsigned        radix;
        int unsigned        digit;
        int unsigned        digit_room;
        int unsigned        pad;
        logic [7:0]         digits_q[$];
        logic [7:0]         chars_q[$];
        logic               overflow;
        field_char_t        one;

        mode = (mode_in > MODE_UNS) ? MODE_DEC : mode_in;
        radix = (mode == MODE_OCT) ? 8 :
                ((mode == MODE_HEX_LO || mode == MODE_HEX_UP) ? 16 : 10);
        letter = (mode == MODE_HEX_UP) ? CH_UPPER : CH_LOWER;
        fill_ch = zero_fill ? CH_ZERO : CH_SPACE;
        neg = (mode != MODE_UNS) && value[VALUE_W-1];
        // Two's complement negation also gives 2^31 for the most negative value.
        mag = neg ? (~value + 1'b1) : value;
        pad = 0;
        overflow = 1'b0;

        if (mag == 0) begin
            digits_q.push_back((mode == MODE_DEC_BLANK) ? CH_SPACE : CH_ZERO);
        end else begin
            while (mag != 0) begin
                digit = mag % radix;
                digits_q.push_back(digit < 10 ? CH_ZERO + 8'(digit) : letter + 8'(digit - 10));
                mag = mag / radix;
            end
        end

        // A width above the widest field is held at the widest field.
        if (width > MAX_WIDTH)
            width = W_BITS'(MAX_WIDTH);
        if (width != 0) begin
            digit_room = width - neg;
            if (digits_q.size() > digit_room)
                overflow = 1'b1;
            else
                pad = digit_room - digits_q.size();
        end

        if (overflow) begin
            repeat (width) chars_q.push_back(CH_STAR);
        end else begin
            // The sign goes ahead of a zero fill but sits against the digits after a space fill.
            if (neg && zero_fill)
                chars_q.push_back(CH_MINUS);
            if (!pad_right)
                repeat (pad) chars_q.push_back(fill_ch);
            if (neg && !zero_fill)
                chars_q.push_back(CH_MINUS);
            for (int i = digits_q.size() - 1; i >= 0; i--)
                chars_q.push_back(digits_q[i]);
            if (pad_right)
                repeat (pad) chars_q.push_back(fill_ch);
        end

        foreach (chars_q[i]) begin
            one.ch = chars_q[i];
            one.last = (i == chars_q.size() - 1);
            one.overflowed = overflow;
            expected_chars_q.push_back(one);
        end
    endfunction

    // Offers one item, idling first at the phase's rate, and records its field once the
    // block has taken it. s_tvalid is left high so that a following item can go straight on.
    task automatic send_field(input logic [VALUE_W-1:0] value, input logic [MODE_W-1:0] mode,
                              input logic [W_BITS-1:0] width, input logic zero_fill,
                              input logic pad_right);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= S_TDATA_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({pad_right, zero_fill, width, mode, value});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        format_field(value, mode, width, zero_fill, pad_right);
    endtask

    // Takes the sender off the bus.
    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every character owed so far has come out.
    task automatic wait_drained();
        while (expected_chars_q.size() != 0)
            @(posedge aclk);
    endtask

    // Every character taken by the receiver is compared with the oldest one owed.
    always @(posedge aclk) begin : check_chars
        field_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars_q.size() == 0) begin
                report_mismatch("character with none owed", m_tdata, 0);
            end else begin
                want = expected_chars_q.pop_front();
                if (m_tdata !== want.ch)
                    report_mismatch("out_char", m_tdata, want.ch);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
                if (m_tuser[0] !== want.overflowed)
                    report_mismatch("overflowed", m_tuser[0], want.overflowed);
            end
        end
    end

    // Values that stress the magnitude path: zero, the largest positive, the most negative,
    // minus one and the widest fields.
    task automatic test_field_extremes();
        send_field(32'h0000_0000, MODE_DEC, 5'd0, 1'b0, 1'b0);
        send_field(32'hFFFF_FFFF, MODE_UNS, 5'd0, 1'b0, 1'b0);
        send_field(32'hFFFF_FFFF, MODE_DEC, 5'd0, 1'b0, 1'b0);
        send_field(32'h8000_0000, MODE_DEC, 5'd0, 1'b0, 1'b0);
        send_field(32'h8000_0000, MODE_OCT, 5'd0, 1'b1, 1'b0);
        send_field(32'h8000_0000, MODE_HEX_UP, 5'd31, 1'b1, 1'b1);
        send_field(32'h7FFF_FFFF, MODE_HEX_LO, 5'd31, 1'b0, 1'b0);
    endtask

    // A value with low half BEEF, its upper half clear or set, through every mode, including the two unnamed ones.
    task automatic test_all_modes();
        send_field(32'h0000_BEEF, MODE_DEC, 5'd10, 1'b0, 1'b0);
        send_field(32'h0000_BEEF, MODE_DEC_BLANK, 5'd10, 1'b1, 1'b0);
        send_field(32'hFFFF_BEEF, MODE_OCT, 5'd10, 1'b0, 1'b1);
        send_field(32'h0000_BEEF, MODE_HEX_LO, 5'd10, 1'b1, 1'b1);
        send_field(32'hFFFF_BEEF, MODE_HEX_UP, 5'd10, 1'b0, 1'b0);
        send_field(32'hFFFF_BEEF, MODE_UNS, 5'd10, 1'b1, 1'b0);
        send_field(32'hFFFF_BEEF, MODE_SPARE_6, 5'd10, 1'b0, 1'b0);
        send_field(32'h0000_BEEF, MODE_SPARE_7, 5'd10, 1'b1, 1'b1);
    endtask

    // Sign placement, overflow to asterisks, blank zero and zero fill on the right.
    task automatic test_special_cases();
        // The sign needs a sixth column, so the field overflows.
        send_field(-32'sd12345, MODE_DEC, 5'd5, 1'b0, 1'b0);
        // Exactly fills its width.
        send_field(32'd12345, MODE_DEC, 5'd5, 1'b0, 1'b0);
        // A one-column field leaves no room for any digit after the sign.
        send_field(-32'sd5, MODE_DEC, 5'd1, 1'b1, 1'b0);
        send_field(32'd0, MODE_DEC_BLANK, 5'd4, 1'b1, 1'b0);
        send_field(32'd0, MODE_DEC_BLANK, 5'd0, 1'b0, 1'b0);
        send_field(-32'sd42, MODE_DEC, 5'd8, 1'b1, 1'b1);
        send_field(-32'sd42, MODE_DEC, 5'd8, 1'b0, 1'b0);
        send_field(32'd42, MODE_OCT, 5'd6, 1'b0, 1'b1);
    endtask

    // Random values lean on small magnitudes, negatives and the edges of the range.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2: return 32'd0 - $urandom_range(0, 999);
            3: return $urandom >> $urandom_range(31);
            4: return ~($urandom >> $urandom_range(31));
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    // Widths cluster around the natural length of a field, where overflow and padding meet.
    function automatic logic [W_BITS-1:0] pick_width();
        case ($urandom_range(3))
            0: return 5'd0;
            1: return 5'($urandom_range(1, 12));
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic test_random_fields(input int unsigned count, input int unsigned send_pct,
                                      input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_field(pick_value(), 3'($urandom_range(0, 7)), pick_width(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // The sender holds off until the block has emptied, then starts again from idle.
    task automatic test_pause_until_drained();
        repeat (6)
            send_field(pick_value(), 3'($urandom_range(0, 7)), pick_width(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        stop_sending();
        wait_drained();
        repeat (6)
            send_field(pick_value(), 3'($urandom_range(0, 7)), pick_width(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 18;
        recv_idle_pct = 48;
        test_field_extremes();
        test_all_modes();
        test_special_cases();
        test_random_fields(50, 18, 48);
        test_pause_until_drained();
        test_random_fields(50, 48, 18);
        test_random_fields(50, 0, 0);

        stop_sending();
        wait_drained();
        // Any stray character after the last one owed would show up in this window.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
